### hdl/sdf_pkg.sv
// shared constants and types for the stream distinct filter
// no dependencies; compiled first
package sdf_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned DataW     = 32;

  // entry index and fill count widths
  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef logic [ValueBits-1:0] key_t;
  typedef logic [CntW-1:0]      cnt_t;

  // lookup request from the input stage to the seen-set store
  typedef struct packed {
    logic commit;
    logic restart;
    key_t key;
  } cam_req_t;

  // lookup answer for the item currently in the input stage
  typedef struct packed {
    logic hit;
    logic full;
  } cam_rsp_t;

endpackage

### hdl/sdf_in_if.sv
// input channel of the stream distinct filter: valid/ready plus item fields
// depends on sdf_pkg
interface sdf_in_if;
  import sdf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic                    restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink (input valid, input value, input restart, output ready);

endinterface

### hdl/sdf_out_if.sv
// result channel of the stream distinct filter: valid/ready plus result fields
// depends on sdf_pkg
interface sdf_out_if;
  import sdf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] unique_value;
  logic                    not_remembered;

  modport source (output valid, output unique_value, output not_remembered, input ready);
  modport sink (input valid, input unique_value, input not_remembered, output ready);

endinterface

### hdl/stream_distinct_filter.sv
// stream distinct filter top: input register, seen-set store, result register
// depends on sdf_pkg, sdf_in_if, sdf_out_if and sdf_cam
// an accepted item passes the input register and the store lookup into the
// result register; one item per cycle while the receiver takes results; the
// compare with all stored entries runs in parallel; a duplicate gives no result
// reset clears the valid flags and the fill count at once; no clearing pass
module stream_distinct_filter (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdf_in_if.sink    in_i,
  sdf_out_if.source out_o
);
  import sdf_pkg::*;

  logic                    in_valid_q;
  logic                    in_valid_d;
  logic signed [DataW-1:0] in_value_q;
  logic                    in_restart_q;
  logic                    res_valid_q;
  logic                    res_valid_d;
  logic signed [DataW-1:0] res_value_q;
  logic                    res_nr_q;
  logic                    advance;
  logic                    load;
  key_t                    key;
  cam_req_t                cam_req;
  cam_rsp_t                cam_rsp;

  // the input stage moves on whenever the result register can take a value
  assign advance    = !res_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign load       = in_i.valid && in_i.ready;

  assign key = key_t'($unsigned(in_value_q));

  assign cam_req.commit  = in_valid_q && advance;
  assign cam_req.restart = in_restart_q;
  assign cam_req.key     = key;

  sdf_cam u_cam (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cam_req),
    .rsp_o  (cam_rsp)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (cam_req.commit) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cam_req.commit) begin
      res_valid_d = !cam_rsp.hit;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_value_q   <= in_i.value;
      in_restart_q <= in_i.restart;
    end
    if (cam_req.commit && !cam_rsp.hit) begin
      res_value_q <= signed'(DataW'(key));
      res_nr_q    <= cam_rsp.full;
    end
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.unique_value   = res_value_q;
  assign out_o.not_remembered = res_nr_q;

endmodule

### hdl/sdf_cam.sv
// seen-set store: row of compare cells with a fill count, a miss appended unless full
// depends on sdf_pkg
module sdf_cam (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdf_pkg::cam_req_t req_i,
  output sdf_pkg::cam_rsp_t rsp_o
);
  import sdf_pkg::*;

  key_t            entry_q [Capacity];
  cnt_t            fill_q;
  cnt_t            fill_d;
  cnt_t            fill_eff;
  logic [Capacity-1:0] match;
  logic            hit;
  logic            full;
  logic [IdxW-1:0] wr_idx;

  // a restart empties the set before this item is looked up
  assign fill_eff = req_i.restart ? '0 : fill_q;

  // only entries below the fill count take part
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    assign match[i] = (cnt_t'(i) < fill_eff) && (entry_q[i] == req_i.key);
  end

  assign hit    = |match;
  assign full   = (fill_eff >= cnt_t'(Capacity));
  assign wr_idx = fill_eff[IdxW-1:0];

  assign rsp_o.hit  = hit;
  assign rsp_o.full = full;

  always_comb begin
    fill_d = fill_q;
    if (req_i.commit) begin
      fill_d = fill_eff;
      if (!hit && !full) begin
        fill_d = fill_eff + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.commit && !hit && !full) begin
      entry_q[wr_idx] <= req_i.key;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cnt_t'(Capacity))
    else $error("fill count beyond capacity");

  a_hit_keeps_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.commit && hit && !req_i.restart |=> $stable(fill_q))
    else $error("fill count moved on a duplicate");

  a_miss_appends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.commit && !hit && !full |=> fill_q == $past(fill_eff) + cnt_t'(1))
    else $error("new value not appended");

  a_restart_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.restart |-> !hit)
    else $error("hit right after restart");

endmodule

### sim/tb.sv
// self-checking testbench for stream_distinct_filter: first-occurrence filtering
// with restart and store-full behavior, checked against a scoreboard predictor
// depends on sdf_pkg, sdf_in_if, sdf_out_if and the filter rtl
module tb;
  import sdf_pkg::*;

  localparam int unsigned RandomItems = 2000;
  localparam int unsigned CycleLimit  = 250000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned FillPool    = 80;
  localparam int unsigned MixPool     = 8;

  typedef logic signed [DataW-1:0] value_t;

  typedef struct packed {
    value_t unique_value;
    logic   not_remembered;
  } distinct_result_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_BURSTY,
    RX_ALTERNATE
  } rx_mode_e;

  typedef enum logic [1:0] {
    EP_MIXED,
    EP_FILL,
    EP_NOISE,
    EP_CORNER
  } episode_e;

  class distinct_scoreboard;
    key_t             seen_keys[Capacity];
    int unsigned      fill;
    distinct_result_t pending[$];
    int unsigned      errors;
    int unsigned      num_inputs;
    int unsigned      num_restarts;
    int unsigned      num_results;
    int unsigned      num_full;

    function new();
      fill         = 0;
      errors       = 0;
      num_inputs   = 0;
      num_restarts = 0;
      num_results  = 0;
      num_full     = 0;
    endfunction

    // predict the result of one accepted input transfer
    function void note_input(value_t value, logic restart);
      key_t             key;
      bit               hit;
      distinct_result_t res;
      key = value[ValueBits-1:0];
      num_inputs++;
      if (restart) begin
        fill = 0;
        num_restarts++;
      end
      hit = 1'b0;
      for (int unsigned i = 0; i < fill; i++) begin
        if (seen_keys[i] == key) hit = 1'b1;
      end
      if (!hit) begin
        res.unique_value   = key;
        res.not_remembered = (fill >= Capacity);
        if (!res.not_remembered) begin
          seen_keys[fill] = key;
          fill++;
        end
        pending.push_back(res);
      end
    endfunction

    function void check_result(value_t unique_value, logic not_remembered);
      distinct_result_t exp_res;
      num_results++;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: unique_value %0d not_remembered %0b",
               unique_value, not_remembered);
        errors++;
      end else begin
        exp_res = pending.pop_front();
        if (exp_res.not_remembered) num_full++;
        if (unique_value !== exp_res.unique_value) begin
          $error("unique_value mismatch: expected %0d actual %0d",
                 exp_res.unique_value, unique_value);
          errors++;
        end
        if (not_remembered !== exp_res.not_remembered) begin
          $error("not_remembered mismatch: expected %0b actual %0b",
                 exp_res.not_remembered, not_remembered);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sdf_in_if  in_if ();
  sdf_out_if out_if ();

  stream_distinct_filter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  distinct_scoreboard sb;
  int unsigned        burst_left;
  int unsigned        cycle_count;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // one input transfer, with a random gap before each new burst
  task automatic send_item(input value_t value, input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid   <= 1'b1;
    in_if.value   <= value;
    in_if.restart <= restart;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(value, restart);
  endtask

  function automatic value_t corner_value(int unsigned k);
    case (k % 8)
      0:       return 32'sh8000_0000;
      1:       return 32'sh8000_0001;
      2:       return 32'sh7fff_ffff;
      3:       return 32'sh7fff_fffe;
      4:       return 32'sh0000_0000;
      5:       return 32'sh0000_0001;
      6:       return 32'shffff_ffff;
      default: return 32'sh5555_5555;
    endcase
  endfunction

  // receiver ready pattern, switching between a few stall styles
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_stall_left;
  bit          rx_phase;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_mode_left = 0;
      rx_stall_left = 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(4, 40);
      end
      rx_mode_left--;
      rx_phase = ~rx_phase;
      case (rx_mode)
        RX_ALWAYS: begin
          out_if.ready <= 1'b1;
        end
        RX_COIN: begin
          out_if.ready <= 1'($urandom_range(0, 1));
        end
        RX_BURSTY: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            out_if.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            rx_stall_left = $urandom_range(1, 12);
            out_if.ready <= 1'b0;
          end else begin
            out_if.ready <= 1'b1;
          end
        end
        default: begin
          out_if.ready <= rx_phase;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.unique_value, out_if.not_remembered);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  episode_e    episode;
  value_t      fill_pool[FillPool];
  value_t      mix_pool[MixPool];
  int unsigned random_end;
  int unsigned fill_len;
  int unsigned ep_len;

  initial begin
    sb             = new();
    burst_left     = 0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.value    = '0;
    in_if.restart  = 1'b0;
    out_if.ready   = 1'b0;
    rx_phase       = 1'b0;
    rx_mode        = RX_ALWAYS;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, duplicates, restart on a duplicate
    send_item(32'sh0000_0000, 1'b1);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'shffff_ffff, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(32'sh7fff_ffff, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0000_0000, 1'b1);
    send_item(32'sh0000_0000, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'shffff_ffff, 1'b0);
    send_item(32'sh0000_0001, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shaaaa_aaaa, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shaaaa_aaaa, 1'b1);
    send_item(32'shaaaa_aaaa, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'sh0000_0001, 1'b1);

    random_end = sb.num_inputs + RandomItems;
    while (sb.num_inputs < random_end) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: episode = EP_MIXED;
        5, 6, 7:       episode = EP_FILL;
        8:             episode = EP_NOISE;
        default:       episode = EP_CORNER;
      endcase
      case (episode)
        EP_MIXED: begin
          // small pool gives frequent duplicates
          for (int unsigned k = 0; k < MixPool; k++) begin
            mix_pool[k] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15);
          end
          ep_len = $urandom_range(1, 40);
          send_item(mix_pool[$urandom_range(0, MixPool - 1)], 1'b1);
          for (int unsigned k = 1; k < ep_len; k++) begin
            if ($urandom_range(0, 9) < 6) begin
              send_item(mix_pool[$urandom_range(0, MixPool - 1)], 1'b0);
            end else begin
              send_item($urandom, 1'b0);
            end
          end
        end
        EP_FILL: begin
          // fill the store to capacity or past it, then repeat remembered and dropped values
          for (int unsigned k = 0; k < FillPool; k++) fill_pool[k] = $urandom;
          fill_len = Capacity + $urandom_range(0, 15);
          send_item(fill_pool[0], 1'b1);
          for (int unsigned k = 1; k < fill_len; k++) send_item(fill_pool[k], 1'b0);
          repeat ($urandom_range(5, 20)) begin
            send_item(fill_pool[$urandom_range(0, fill_len - 1)],
                      ($urandom_range(0, 31) == 0));
          end
        end
        EP_NOISE: begin
          repeat ($urandom_range(1, 20)) send_item($urandom, 1'($urandom_range(0, 1)));
        end
        default: begin
          repeat ($urandom_range(1, 20)) begin
            send_item(corner_value($urandom_range(0, 7)), ($urandom_range(0, 9) == 0));
          end
        end
      endcase
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d input transfers with %0d restarts and %0d result transfers,",
             sb.num_inputs, sb.num_restarts, sb.num_results);
    $display("%0d of them passed on while the store was full, %0d mismatches",
             sb.num_full, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
